@@ rtl/pmb_pkg.sv @@
// Projection matrix builder package: shared types, constants and the
// IEEE single-precision add, multiply and rounding functions.
// No dependencies.
`default_nettype none

package pmb_pkg;

   localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
   localparam logic [31:0] FP_NEG_ONE  = 32'hBF80_0000;
   localparam logic [31:0] FP_TWO      = 32'h4000_0000;
   localparam logic [31:0] FP_NEG_TWO  = 32'hC000_0000;
   localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
   localparam logic [31:0] FP_QNAN     = 32'hFFC0_0000;
   localparam logic [31:0] FP_QBIT     = 32'h0040_0000;

   localparam int NUM_SUMS = 6;
   localparam int NUM_MULS = 3;
   localparam int NUM_DIVS = 6;
   localparam int NUM_ROWS = 4;
   localparam int QUO_BITS = 26;

   localparam logic CSR_PROJ_MODE    = 1'b0;
   localparam logic CSR_RIGHT_HANDED = 1'b1;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] bottom;
      logic [31:0] top;
      logic [31:0] near_d;
      logic [31:0] far_d;
      logic        persp;
      logic        rh;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quo;
   } div_rsp_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ADD,
      B_CHECK,
      B_MUL,
      B_DIV_GO,
      B_DIV_WAIT,
      B_EMIT,
      B_ERROR
   } back_state_type;

   function automatic logic fp_is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(input logic [31:0] a);
      return a[30:0] == 31'h7F80_0000;
   endfunction

   function automatic logic fp_is_zero(input logic [31:0] a);
      return a[30:0] == 31'd0;
   endfunction

   function automatic logic fp_is_pos(input logic [31:0] a);
      return !a[31] && !fp_is_zero(a) && !fp_is_nan(a);
   endfunction

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // v holds the hidden bit at 26, fraction below, then guard, round, sticky
   function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                           input logic [26:0] v);
      logic [26:0]        w;
      logic signed [11:0] ef;
      logic [11:0]        sh;
      logic               up;
      logic [24:0]        s25;
      logic [23:0]        sig;
      logic [31:0]        res;
      w = v;
      ef = e;
      sh = 12'd0;
      if (e < 12'sd1) begin
         sh = 12'sd1 - e;
         if (sh >= 12'd27) begin
            w = {26'd0, |v};
         end else begin
            w = (v >> sh[4:0]) | {26'd0, |(v & ~({27{1'b1}} << sh[4:0]))};
         end
         ef = 12'sd1;
      end
      up = w[2] & (w[1] | w[0] | w[3]);
      s25 = {1'b0, w[26:3]} + {24'd0, up};
      if (s25[24]) begin
         sig = s25[24:1];
         ef = ef + 12'sd1;
      end else begin
         sig = s25[23:0];
      end
      if (ef >= 12'sd255) begin
         res = {s, 8'hFF, 23'd0};
      end else begin
         res = {s, (sig[23] ? ef[7:0] : 8'h00), sig[22:0]};
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b,
                                          input logic sub);
      logic [31:0]        bn;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [7:0]         ex;
      logic [7:0]         ey;
      logic [7:0]         d;
      logic [26:0]        mx;
      logic [26:0]        my;
      logic [26:0]        ms;
      logic [26:0]        mask;
      logic [27:0]        sum;
      logic [26:0]        v;
      logic signed [11:0] e;
      logic signed [11:0] lim;
      logic [4:0]         lz;
      logic [11:0]        sh;
      logic [31:0]        res;
      bn = b ^ {sub, 31'd0};
      res = FP_QNAN;
      if (fp_is_nan(a)) begin
         res = a | FP_QBIT;
      end else if (fp_is_nan(b)) begin
         res = b | FP_QBIT;
      end else if (fp_is_inf(a) && fp_is_inf(bn)) begin
         res = (a[31] == bn[31]) ? a : FP_QNAN;
      end else if (fp_is_inf(a)) begin
         res = a;
      end else if (fp_is_inf(bn)) begin
         res = bn;
      end else begin
         if (bn[30:0] > a[30:0]) begin
            x = bn;
            y = a;
         end else begin
            x = a;
            y = bn;
         end
         ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
         ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
         mx = {x[30:23] != 8'd0, x[22:0], 3'b000};
         my = {y[30:23] != 8'd0, y[22:0], 3'b000};
         d = ex - ey;
         mask = ~({27{1'b1}} << d);
         if (d >= 8'd27) begin
            ms = {26'd0, |my};
         end else begin
            ms = (my >> d) | {26'd0, |(my & mask)};
         end
         if (x[31] ^ y[31]) begin
            sum = {1'b0, mx} - {1'b0, ms};
         end else begin
            sum = {1'b0, mx} + {1'b0, ms};
         end
         e = 12'(ex);
         lz = lzc27(sum[26:0]);
         lim = e - 12'sd1;
         sh = (12'(lz) < lim) ? 12'(lz) : lim;
         v = sum[26:0] << sh;
         if (sum == 28'd0) begin
            res = {x[31] & y[31], 31'd0};
         end else if (sum[27]) begin
            res = fp_pack(x[31], e + 12'sd1, {sum[27:2], sum[1] | sum[0]});
         end else begin
            res = fp_pack(x[31], e - sh, v);
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic               s;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        p;
      logic [5:0]         lz;
      logic signed [11:0] e;
      logic [31:0]        res;
      s = a[31] ^ b[31];
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p = ma * mb;
      lz = lzc48(p);
      p = p << lz;
      e = 12'(ea) + 12'(eb) - 12'd126 - 12'(lz);
      if (fp_is_nan(a)) begin
         res = a | FP_QBIT;
      end else if (fp_is_nan(b)) begin
         res = b | FP_QBIT;
      end else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) begin
         res = FP_QNAN;
      end else if (fp_is_inf(a) || fp_is_inf(b)) begin
         res = {s, 8'hFF, 23'd0};
      end else if (fp_is_zero(a) || fp_is_zero(b)) begin
         res = {s, 31'd0};
      end else begin
         res = fp_pack(s, e, {p[47:22], |p[21:0]});
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/projection_matrix_builder_top.sv @@
// Projection matrix builder top level: front end, work queue, back end and
// divider. Depends on pmb_pkg, pmb_front, pmb_fifo, pmb_fdiv, pmb_back.
`default_nettype none

// Takes six IEEE single view-volume bounds per item and returns the 4x4
// perspective or orthographic projection matrix as four row transfers, the
// last flagged; bounds that fail the check return one row-0 transfer with
// bad_bounds set and zero elements. A two-entry queue takes new items while
// the back end works. For each valid item the back end forms six sums, three
// products (perspective only) and six divisions on the single bit-serial
// divider, then emits the four rows. Configuration writes take effect on
// items accepted afterwards.
module projection_matrix_builder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_bound_left,
   input  wire logic [31:0] req_bound_right,
   input  wire logic [31:0] req_bound_bottom,
   input  wire logic [31:0] req_bound_top,
   input  wire logic [31:0] req_near_depth,
   input  wire logic [31:0] req_far_depth,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_row_index,
   output logic [31:0]      rsp_elem_a,
   output logic [31:0]      rsp_elem_b,
   output logic [31:0]      rsp_elem_c,
   output logic [31:0]      rsp_elem_d,
   output logic             rsp_last_row,
   output logic             rsp_bad_bounds,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic        csr_data
);
   import pmb_pkg::*;

   logic        q_full;
   logic        q_push;
   item_type    q_item;
   logic        q_pop;
   logic        q_empty;
   item_type    q_head;
   div_req_type div_req;
   div_rsp_type div_rsp;

   pmb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bound_left   (req_bound_left),
      .req_bound_right  (req_bound_right),
      .req_bound_bottom (req_bound_bottom),
      .req_bound_top    (req_bound_top),
      .req_near_depth   (req_near_depth),
      .req_far_depth    (req_far_depth),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_item)
   );

   pmb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   pmb_fdiv u_fdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pmb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_index  (rsp_row_index),
      .rsp_elem_a     (rsp_elem_a),
      .rsp_elem_b     (rsp_elem_b),
      .rsp_elem_c     (rsp_elem_c),
      .rsp_elem_d     (rsp_elem_d),
      .rsp_last_row   (rsp_last_row),
      .rsp_bad_bounds (rsp_bad_bounds)
   );

   a_bad_single_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_bounds |-> rsp_row_index == 2'd0 && rsp_last_row)
      else $error("bad bounds result not a single last row");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_row == (rsp_bad_bounds || rsp_row_index == 2'd3))
      else $error("last row flag mismatch");

   a_rows_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=>
         rsp_valid && rsp_row_index == 2'($past(rsp_row_index) + 2'd1))
      else $error("row transfers not consecutive");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ rtl/pmb_front.sv @@
// Projection matrix builder front end: configuration registers and input
// capture into the work queue. Depends on pmb_pkg.
`default_nettype none

module pmb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [31:0]       req_bound_left,
   input  wire logic [31:0]       req_bound_right,
   input  wire logic [31:0]       req_bound_bottom,
   input  wire logic [31:0]       req_bound_top,
   input  wire logic [31:0]       req_near_depth,
   input  wire logic [31:0]       req_far_depth,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic              csr_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output pmb_pkg::item_type      q_item
);
   import pmb_pkg::*;

   logic persp_ff, persp_in;
   logic rh_ff, rh_in;

   always_comb begin
      persp_in = persp_ff;
      rh_in = rh_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROJ_MODE:    persp_in = csr_data;
            CSR_RIGHT_HANDED: rh_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         persp_ff <= 1'b1;
         rh_ff <= 1'b0;
      end else begin
         persp_ff <= persp_in;
         rh_ff <= rh_in;
      end
   end

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      q_item.left = req_bound_left;
      q_item.right = req_bound_right;
      q_item.bottom = req_bound_bottom;
      q_item.top = req_bound_top;
      q_item.near_d = req_near_depth;
      q_item.far_d = req_far_depth;
      q_item.persp = persp_ff;
      q_item.rh = rh_ff;
   end

endmodule

`default_nettype wire

@@ rtl/pmb_fifo.sv @@
// Projection matrix builder work queue: two entries between front and back.
// Depends on pmb_pkg.
`default_nettype none

module pmb_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  pmb_pkg::item_type      push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output pmb_pkg::item_type      head
);
   import pmb_pkg::*;

   item_type   mem_ff [2];
   item_type   mem_in [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head = mem_ff[rd_ff];

   always_comb begin
      mem_in = mem_ff;
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         mem_in[wr_ff] = push_item;
         wr_in = !wr_ff;
      end
      if (pop) begin
         rd_in = !rd_ff;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pmb_fdiv.sv @@
// Projection matrix builder divider: IEEE single division, one quotient bit
// per cycle, round to nearest even. Depends on pmb_pkg.
`default_nettype none

module pmb_fdiv (
   input  wire logic              clock,
   input  wire logic              reset,
   input  pmb_pkg::div_req_type   div_req,
   output pmb_pkg::div_rsp_type   div_rsp
);
   import pmb_pkg::*;

   logic               run_ff, run_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [24:0]        rem_ff, rem_in;
   logic [23:0]        den_ff, den_in;
   logic [25:0]        q_ff, q_in;
   logic signed [11:0] exp_ff, exp_in;
   logic               sgn_ff, sgn_in;
   logic [31:0]        quo_ff, quo_in;

   logic [31:0]        na;
   logic [31:0]        nb;
   logic               s;
   logic [7:0]         ea;
   logic [7:0]         eb;
   logic [23:0]        ma;
   logic [23:0]        mb;
   logic [4:0]         lza;
   logic [4:0]         lzb;
   logic signed [11:0] ediff;
   logic [24:0]        diff;

   assign na = div_req.num;
   assign nb = div_req.den;
   assign s = na[31] ^ nb[31];
   assign ea = (na[30:23] == 8'd0) ? 8'd1 : na[30:23];
   assign eb = (nb[30:23] == 8'd0) ? 8'd1 : nb[30:23];
   assign lza = lzc24({na[30:23] != 8'd0, na[22:0]});
   assign lzb = lzc24({nb[30:23] != 8'd0, nb[22:0]});
   assign ma = {na[30:23] != 8'd0, na[22:0]} << lza;
   assign mb = {nb[30:23] != 8'd0, nb[22:0]} << lzb;
   assign ediff = 12'(ea) - 12'(lza) - 12'(eb) + 12'(lzb) + 12'd127;
   assign diff = rem_ff - {1'b0, den_ff};

   always_comb begin
      run_in = run_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      exp_in = exp_ff;
      sgn_in = sgn_ff;
      quo_in = quo_ff;
      priority if (div_req.start) begin
         sgn_in = s;
         priority if (fp_is_nan(na)) begin
            quo_in = na | FP_QBIT;
            done_in = 1'b1;
         end else if (fp_is_nan(nb)) begin
            quo_in = nb | FP_QBIT;
            done_in = 1'b1;
         end else if ((fp_is_inf(na) && fp_is_inf(nb)) ||
                      (fp_is_zero(na) && fp_is_zero(nb))) begin
            quo_in = FP_QNAN;
            done_in = 1'b1;
         end else if (fp_is_inf(na) || fp_is_zero(nb)) begin
            quo_in = {s, 8'hFF, 23'd0};
            done_in = 1'b1;
         end else if (fp_is_zero(na) || fp_is_inf(nb)) begin
            quo_in = {s, 31'd0};
            done_in = 1'b1;
         end else begin
            run_in = 1'b1;
            cnt_in = 5'd0;
            q_in = 26'd0;
            den_in = mb;
            if (ma >= mb) begin
               rem_in = {1'b0, ma};
               exp_in = ediff;
            end else begin
               rem_in = {ma, 1'b0};
               exp_in = ediff - 12'sd1;
            end
         end
      end else if (run_ff) begin
         if (!diff[24]) begin
            rem_in = {diff[23:0], 1'b0};
            q_in = {q_ff[24:0], 1'b1};
         end else begin
            rem_in = {rem_ff[23:0], 1'b0};
            q_in = {q_ff[24:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(QUO_BITS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         quo_in = fp_pack(sgn_ff, exp_ff, {q_ff, rem_ff != 25'd0});
         done_in = 1'b1;
      end else begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      exp_ff <= exp_in;
      sgn_ff <= sgn_in;
      quo_ff <= quo_in;
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo = quo_ff;

endmodule

`default_nettype wire

@@ rtl/pmb_back.sv @@
// Projection matrix builder back end: sequences the sums, products and
// divisions of one item and drives the row result register. Depends on pmb_pkg.
`default_nettype none

module pmb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  pmb_pkg::item_type      q_head,
   output logic                   q_pop,
   output pmb_pkg::div_req_type   div_req,
   input  pmb_pkg::div_rsp_type   div_rsp,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_row_index,
   output logic [31:0]            rsp_elem_a,
   output logic [31:0]            rsp_elem_b,
   output logic [31:0]            rsp_elem_c,
   output logic [31:0]            rsp_elem_d,
   output logic                   rsp_last_row,
   output logic                   rsp_bad_bounds
);
   import pmb_pkg::*;

   back_state_type state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic [31:0]    sum_ff [NUM_SUMS];
   logic [31:0]    sum_in [NUM_SUMS];
   logic [31:0]    mq_ff [NUM_MULS];
   logic [31:0]    mq_in [NUM_MULS];
   logic [31:0]    res_ff [NUM_DIVS];
   logic [31:0]    res_in [NUM_DIVS];
   logic           valid_ff, valid_in;
   logic [1:0]     row_ff, row_in;
   logic [31:0]    ea_ff, ea_in, eb_ff, eb_in, ec_ff, ec_in, ed_ff, ed_in;
   logic           last_ff, last_in;
   logic           bad_ff, bad_in;

   logic        out_free;
   logic        ok;
   logic        store_add;
   logic        store_mul;
   logic        store_div;
   logic        load_row;
   logic        load_err;
   logic [31:0] add_a, add_b;
   logic        add_sub;
   logic [31:0] mul_a, mul_b;
   logic [31:0] num, den;
   logic [31:0] row_a, row_b, row_c, row_d;
   logic [31:0] neg_sx, neg_sy, neg_sz;
   logic [31:0] sign_one;

   assign out_free = !valid_ff || !rsp_stall;
   assign neg_sx = {~sum_ff[3][31], sum_ff[3][30:0]};
   assign neg_sy = {~sum_ff[4][31], sum_ff[4][30:0]};
   assign neg_sz = {~sum_ff[5][31], sum_ff[5][30:0]};
   assign sign_one = q_head.rh ? FP_NEG_ONE : FP_ONE;

   always_comb begin
      if (q_head.persp) begin
         ok = fp_is_pos(q_head.near_d) && fp_is_pos(q_head.far_d) &&
              fp_is_pos(sum_ff[0]) && fp_is_pos(sum_ff[1]) && fp_is_pos(sum_ff[2]);
      end else begin
         ok = !fp_is_zero(sum_ff[0]) && !fp_is_zero(sum_ff[1]) && !fp_is_zero(sum_ff[2]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:     if (!q_empty) state_in = B_ADD;
         B_ADD:      if (cnt_ff == 3'(NUM_SUMS - 1)) state_in = B_CHECK;
         B_CHECK: begin
            priority if (!ok) state_in = B_ERROR;
            else if (q_head.persp) state_in = B_MUL;
            else state_in = B_DIV_GO;
         end
         B_MUL:      if (cnt_ff == 3'(NUM_MULS - 1)) state_in = B_DIV_GO;
         B_DIV_GO:   state_in = B_DIV_WAIT;
         B_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (cnt_ff == 3'(NUM_DIVS - 1)) ? B_EMIT : B_DIV_GO;
            end
         end
         B_EMIT:     if (out_free && cnt_ff == 3'(NUM_ROWS - 1)) state_in = B_IDLE;
         B_ERROR:    if (out_free) state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      store_add = 1'b0;
      store_mul = 1'b0;
      store_div = 1'b0;
      load_row = 1'b0;
      load_err = 1'b0;
      q_pop = 1'b0;
      div_req.start = 1'b0;
      unique case (state_ff)
         B_IDLE:  cnt_in = 3'd0;
         B_ADD: begin
            store_add = 1'b1;
            cnt_in = (cnt_ff == 3'(NUM_SUMS - 1)) ? 3'd0 : cnt_ff + 3'd1;
         end
         B_CHECK: cnt_in = 3'd0;
         B_MUL: begin
            store_mul = 1'b1;
            cnt_in = (cnt_ff == 3'(NUM_MULS - 1)) ? 3'd0 : cnt_ff + 3'd1;
         end
         B_DIV_GO: div_req.start = 1'b1;
         B_DIV_WAIT: begin
            if (div_rsp.done) begin
               store_div = 1'b1;
               cnt_in = (cnt_ff == 3'(NUM_DIVS - 1)) ? 3'd0 : cnt_ff + 3'd1;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               load_row = 1'b1;
               q_pop = cnt_ff == 3'(NUM_ROWS - 1);
               cnt_in = (cnt_ff == 3'(NUM_ROWS - 1)) ? 3'd0 : cnt_ff + 3'd1;
            end
         end
         B_ERROR: begin
            load_err = out_free;
            q_pop = out_free;
         end
         default: cnt_in = 3'd0;
      endcase
   end

   always_comb begin
      add_sub = 1'b1;
      unique case (cnt_ff)
         3'd0: begin add_a = q_head.right;  add_b = q_head.left;   end
         3'd1: begin add_a = q_head.top;    add_b = q_head.bottom; end
         3'd2: begin add_a = q_head.far_d;  add_b = q_head.near_d; end
         3'd3: begin add_a = q_head.right;  add_b = q_head.left;   add_sub = 1'b0; end
         3'd4: begin add_a = q_head.top;    add_b = q_head.bottom; add_sub = 1'b0; end
         3'd5: begin add_a = q_head.near_d; add_b = q_head.far_d;  add_sub = 1'b0; end
         default: begin add_a = FP_ZERO; add_b = FP_ZERO; end
      endcase
      unique case (cnt_ff)
         3'd0:    begin mul_a = FP_TWO;     mul_b = q_head.near_d; end
         3'd1:    begin mul_a = FP_NEG_TWO; mul_b = q_head.near_d; end
         3'd2:    begin mul_a = mq_ff[1];   mul_b = q_head.far_d;  end
         default: begin mul_a = FP_ZERO;    mul_b = FP_ZERO;       end
      endcase
      if (q_head.persp) begin
         unique case (cnt_ff)
            3'd0:    begin num = mq_ff[0]; den = sum_ff[0]; end
            3'd1:    begin num = mq_ff[0]; den = sum_ff[1]; end
            3'd2:    begin num = sum_ff[3]; den = sum_ff[0]; end
            3'd3:    begin num = sum_ff[4]; den = sum_ff[1]; end
            3'd4:    begin num = q_head.rh ? neg_sz : sum_ff[5]; den = sum_ff[2]; end
            3'd5:    begin num = mq_ff[2]; den = sum_ff[2]; end
            default: begin num = FP_ZERO; den = FP_ZERO; end
         endcase
      end else begin
         unique case (cnt_ff)
            3'd0:    begin num = FP_TWO; den = sum_ff[0]; end
            3'd1:    begin num = FP_TWO; den = sum_ff[1]; end
            3'd2:    begin num = q_head.rh ? FP_NEG_TWO : FP_TWO; den = sum_ff[2]; end
            3'd3:    begin num = neg_sx; den = sum_ff[0]; end
            3'd4:    begin num = neg_sy; den = sum_ff[1]; end
            3'd5:    begin num = neg_sz; den = sum_ff[2]; end
            default: begin num = FP_ZERO; den = FP_ZERO; end
         endcase
      end
      row_a = FP_ZERO;
      row_b = FP_ZERO;
      row_c = FP_ZERO;
      row_d = FP_ZERO;
      if (q_head.persp) begin
         unique case (cnt_ff[1:0])
            2'd0: row_a = res_ff[0];
            2'd1: row_b = res_ff[1];
            2'd2: begin
               row_a = res_ff[2];
               row_b = res_ff[3];
               row_c = res_ff[4];
               row_d = sign_one;
            end
            2'd3: row_c = res_ff[5];
         endcase
      end else begin
         unique case (cnt_ff[1:0])
            2'd0: row_a = res_ff[0];
            2'd1: row_b = res_ff[1];
            2'd2: row_c = res_ff[2];
            2'd3: begin
               row_a = res_ff[3];
               row_b = res_ff[4];
               row_c = res_ff[5];
               row_d = FP_ONE;
            end
         endcase
      end
   end

   assign div_req.num = num;
   assign div_req.den = den;

   always_comb begin
      sum_in = sum_ff;
      mq_in = mq_ff;
      res_in = res_ff;
      valid_in = valid_ff && rsp_stall;
      row_in = row_ff;
      ea_in = ea_ff;
      eb_in = eb_ff;
      ec_in = ec_ff;
      ed_in = ed_ff;
      last_in = last_ff;
      bad_in = bad_ff;
      if (store_add) sum_in[cnt_ff] = fp_add(add_a, add_b, add_sub);
      if (store_mul) mq_in[cnt_ff[1:0]] = fp_mul(mul_a, mul_b);
      if (store_div) res_in[cnt_ff] = div_rsp.quo;
      if (load_row) begin
         valid_in = 1'b1;
         row_in = cnt_ff[1:0];
         ea_in = row_a;
         eb_in = row_b;
         ec_in = row_c;
         ed_in = row_d;
         last_in = cnt_ff == 3'(NUM_ROWS - 1);
         bad_in = 1'b0;
      end else if (load_err) begin
         valid_in = 1'b1;
         row_in = 2'd0;
         ea_in = FP_ZERO;
         eb_in = FP_ZERO;
         ec_in = FP_ZERO;
         ed_in = FP_ZERO;
         last_in = 1'b1;
         bad_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      mq_ff <= mq_in;
      res_ff <= res_in;
      row_ff <= row_in;
      ea_ff <= ea_in;
      eb_ff <= eb_in;
      ec_ff <= ec_in;
      ed_ff <= ed_in;
      last_ff <= last_in;
      bad_ff <= bad_in;
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_elem_a = ea_ff;
   assign rsp_elem_b = eb_ff;
   assign rsp_elem_c = ec_ff;
   assign rsp_elem_d = ed_ff;
   assign rsp_last_row = last_ff;
   assign rsp_bad_bounds = bad_ff;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for projection_matrix_builder_top: drives view-volume bounds under both
// projection modes and handedness settings, and checks each row against a bit-exact
// IEEE single-precision predictor. Depends on pmb_pkg and the RTL top level.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pmb_pkg::*;

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] bottom;
      logic [31:0] top;
      logic [31:0] near_d;
      logic [31:0] far_d;
   } bounds_type;

   typedef struct {
      logic [1:0]  row_index;
      logic [31:0] elem_a;
      logic [31:0] elem_b;
      logic [31:0] elem_c;
      logic [31:0] elem_d;
      logic        last_row;
      logic        bad_bounds;
   } row_type;

   class matrix_scoreboard;
      bit      persp = 1'b1;
      bit      rh = 1'b0;
      row_type rows_due[$];
      int      errors = 0;

      function automatic logic [31:0] round_pack(logic s, int e, logic [63:0] m);
         int           lsb_exp;
         int           sh;
         logic [127:0] t;
         logic [63:0]  q;
         logic         g;
         logic         st;
         longint       v;
         if (m == 64'd0) return {s, 31'd0};
         while (!m[63]) begin
            m = m << 1;
            e = e - 1;
         end
         lsb_exp = (e + 63 - 23 > -149) ? e + 63 - 23 : -149;
         sh = lsb_exp - e;
         if (sh >= 65) begin
            q = 64'd0;
            g = 1'b0;
            st = 1'b1;
         end else begin
            t = {m, 64'd0} >> sh;
            q = t[127:64];
            g = t[63];
            st = |t[62:0];
         end
         if (g && (st || q[0])) q = q + 64'd1;
         v = (longint'(lsb_exp + 149) << 23) + longint'(q);
         if (v >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
         return {s, v[30:0]};
      endfunction

      function automatic void unpack(input logic [31:0] x, output logic [63:0] m,
                                     output int e);
         if (x[30:23] == 8'd0) begin
            m = {41'd0, x[22:0]};
            e = -149;
         end else begin
            m = {40'd0, 1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
         end
      endfunction

      function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
         logic [63:0] ma;
         logic [63:0] mb;
         logic [63:0] ta;
         logic [63:0] tb;
         logic [63:0] sum;
         int          ea;
         int          eb;
         int          d;
         logic        sa;
         logic        sb;
         logic        s;
         if (fp_is_nan(a)) return a | FP_QBIT;
         if (fp_is_nan(b)) return b | FP_QBIT;
         if (fp_is_inf(a) && fp_is_inf(b)) return (a[31] == b[31]) ? a : FP_QNAN;
         if (fp_is_inf(a)) return a;
         if (fp_is_inf(b)) return b;
         unpack(a, ma, ea);
         unpack(b, mb, eb);
         sa = a[31];
         sb = b[31];
         if (ma == 64'd0 && mb == 64'd0) return {sa & sb, 31'd0};
         if (eb > ea) begin
            ta = ma; ma = mb; mb = ta;
            d = ea; ea = eb; eb = d;
            s = sa; sa = sb; sb = s;
         end
         d = ea - eb;
         ta = ma << 38;
         tb = (d <= 38) ? (mb << (38 - d)) : {63'd0, mb != 64'd0};
         if (sa == sb) begin
            sum = ta + tb;
            s = sa;
         end else if (ta >= tb) begin
            sum = ta - tb;
            s = sa;
         end else begin
            sum = tb - ta;
            s = sb;
         end
         if (sum == 64'd0) return FP_ZERO;
         return round_pack(s, ea - 38, sum);
      endfunction

      function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
         if (fp_is_nan(a)) return a | FP_QBIT;
         if (fp_is_nan(b)) return b | FP_QBIT;
         return fadd(a, b ^ 32'h8000_0000);
      endfunction

      function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
         logic [63:0] ma;
         logic [63:0] mb;
         int          ea;
         int          eb;
         logic        s;
         s = a[31] ^ b[31];
         if (fp_is_nan(a)) return a | FP_QBIT;
         if (fp_is_nan(b)) return b | FP_QBIT;
         if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b)))
            return FP_QNAN;
         if (fp_is_inf(a) || fp_is_inf(b)) return {s, 8'hFF, 23'd0};
         if (fp_is_zero(a) || fp_is_zero(b)) return {s, 31'd0};
         unpack(a, ma, ea);
         unpack(b, mb, eb);
         return round_pack(s, ea + eb, ma * mb);
      endfunction

      function automatic logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
         logic [63:0] ma;
         logic [63:0] mb;
         logic [63:0] q;
         logic [63:0] rem;
         int          ea;
         int          eb;
         logic        s;
         s = a[31] ^ b[31];
         if (fp_is_nan(a)) return a | FP_QBIT;
         if (fp_is_nan(b)) return b | FP_QBIT;
         if ((fp_is_inf(a) && fp_is_inf(b)) || (fp_is_zero(a) && fp_is_zero(b)))
            return FP_QNAN;
         if (fp_is_inf(a)) return {s, 8'hFF, 23'd0};
         if (fp_is_inf(b)) return {s, 31'd0};
         if (fp_is_zero(b)) return {s, 8'hFF, 23'd0};
         if (fp_is_zero(a)) return {s, 31'd0};
         unpack(a, ma, ea);
         unpack(b, mb, eb);
         while (!ma[23]) begin
            ma = ma << 1;
            ea = ea - 1;
         end
         while (!mb[23]) begin
            mb = mb << 1;
            eb = eb - 1;
         end
         q = (ma << 40) / mb;
         rem = (ma << 40) % mb;
         return round_pack(s, ea - eb - 41, (q << 1) | {63'd0, rem != 64'd0});
      endfunction

      function automatic void note(bounds_type bd);
         logic [31:0] dx;
         logic [31:0] dy;
         logic [31:0] dz;
         logic [31:0] sx;
         logic [31:0] sy;
         logic [31:0] sz;
         logic [31:0] q;
         logic [31:0] m[4][4];
         logic        ok;
         row_type     r;
         dx = fsub(bd.right, bd.left);
         dy = fsub(bd.top, bd.bottom);
         dz = fsub(bd.far_d, bd.near_d);
         sx = fadd(bd.right, bd.left);
         sy = fadd(bd.top, bd.bottom);
         sz = fadd(bd.near_d, bd.far_d);
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i][j] = FP_ZERO;
         if (persp)
            ok = fp_is_pos(bd.near_d) && fp_is_pos(bd.far_d) && fp_is_pos(dx)
                 && fp_is_pos(dy) && fp_is_pos(dz);
         else
            ok = !fp_is_zero(dx) && !fp_is_zero(dy) && !fp_is_zero(dz);
         if (!ok) begin
            r = '{2'd0, FP_ZERO, FP_ZERO, FP_ZERO, FP_ZERO, 1'b1, 1'b1};
            rows_due.push_back(r);
            return;
         end
         if (persp) begin
            q = fmul(FP_TWO, bd.near_d);
            m[0][0] = fdiv(q, dx);
            m[1][1] = fdiv(q, dy);
            m[2][0] = fdiv(sx, dx);
            m[2][1] = fdiv(sy, dy);
            if (rh) begin
               m[2][2] = fdiv(sz ^ 32'h8000_0000, dz);
               m[2][3] = FP_NEG_ONE;
            end else begin
               m[2][2] = fdiv(sz, dz);
               m[2][3] = FP_ONE;
            end
            q = fmul(FP_NEG_TWO, bd.near_d);
            q = fmul(q, bd.far_d);
            m[3][2] = fdiv(q, dz);
         end else begin
            m[0][0] = fdiv(FP_TWO, dx);
            m[1][1] = fdiv(FP_TWO, dy);
            m[2][2] = fdiv(rh ? FP_NEG_TWO : FP_TWO, dz);
            m[3][0] = fdiv(sx ^ 32'h8000_0000, dx);
            m[3][1] = fdiv(sy ^ 32'h8000_0000, dy);
            m[3][2] = fdiv(sz ^ 32'h8000_0000, dz);
            m[3][3] = FP_ONE;
         end
         for (int i = 0; i < 4; i++) begin
            r = '{2'(i), m[i][0], m[i][1], m[i][2], m[i][3], i == 3, 1'b0};
            rows_due.push_back(r);
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      endtask

      task check(row_type got);
         row_type     want;
         logic [31:0] g[7];
         logic [31:0] w[7];
         string       names[7];
         if (rows_due.size() == 0) begin
            report_mismatch("unexpected row", {30'd0, got.row_index}, 32'd0);
            return;
         end
         want = rows_due.pop_front();
         names = '{"row_index", "elem_a", "elem_b", "elem_c", "elem_d", "last_row",
                   "bad_bounds"};
         g = '{32'(got.row_index), got.elem_a, got.elem_b, got.elem_c, got.elem_d,
               32'(got.last_row), 32'(got.bad_bounds)};
         w = '{32'(want.row_index), want.elem_a, want.elem_b, want.elem_c, want.elem_d,
               32'(want.last_row), 32'(want.bad_bounds)};
         for (int i = 0; i < 7; i++)
            if (g[i] !== w[i]) report_mismatch(names[i], g[i], w[i]);
      endtask
   endclass

   localparam int STALL_LIMIT = 8000;
   localparam int HOLD_CYCLES = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_bound_left = '0;
   logic [31:0] req_bound_right = '0;
   logic [31:0] req_bound_bottom = '0;
   logic [31:0] req_bound_top = '0;
   logic [31:0] req_near_depth = '0;
   logic [31:0] req_far_depth = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_row_index;
   logic [31:0] rsp_elem_a;
   logic [31:0] rsp_elem_b;
   logic [31:0] rsp_elem_c;
   logic [31:0] rsp_elem_d;
   logic        rsp_last_row;
   logic        rsp_bad_bounds;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic        csr_data = 1'b0;

   matrix_scoreboard matrices = new;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_req = 1'b0;
   int  quiet_cycles = 0;

   projection_matrix_builder_top i_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         matrices.check('{rsp_row_index, rsp_elem_a, rsp_elem_b, rsp_elem_c, rsp_elem_d,
                          rsp_last_row, rsp_bad_bounds});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task send_bounds(bounds_type bd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_bound_left <= bd.left;
      req_bound_right <= bd.right;
      req_bound_bottom <= bd.bottom;
      req_bound_top <= bd.top;
      req_near_depth <= bd.near_d;
      req_far_depth <= bd.far_d;
      do @(posedge clock); while (req_stall);
      matrices.note(bd);
   endtask

   task drain;
      req_valid <= 1'b0;
      while (matrices.rows_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_reg(logic idx, logic val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_PROJ_MODE) matrices.persp = val;
      else matrices.rh = val;
   endtask

   function automatic logic [31:0] rand_mag();
      logic [7:0] e;
      e = ($urandom_range(9) == 0) ? 8'($urandom_range(254)) : 8'($urandom_range(145, 110));
      return {1'b0, e, 23'($urandom)};
   endfunction

   function automatic void ordered_pair(output logic [31:0] lo, output logic [31:0] hi,
                                        input bit allow_neg);
      logic [31:0] x;
      logic [31:0] y;
      do begin
         x = rand_mag();
         y = rand_mag();
      end while (x == y);
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      if (allow_neg && $urandom_range(1)) lo[31] = 1'b1;
   endfunction

   function automatic bounds_type make_bounds();
      bounds_type bd;
      int         k;
      k = $urandom_range(99);
      ordered_pair(bd.left, bd.right, 1'b1);
      ordered_pair(bd.bottom, bd.top, 1'b1);
      ordered_pair(bd.near_d, bd.far_d, !matrices.persp);
      if (k >= 90) begin
         bd = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (k >= 78) begin
         case ($urandom_range(5))
            0: bd.left = $urandom;
            1: bd.right = bd.left;
            2: bd.bottom = $urandom;
            3: bd.top = bd.bottom;
            4: bd.near_d = $urandom;
            default: bd.far_d = bd.near_d;
         endcase
      end
      return bd;
   endfunction

   task send_directed;
      bounds_type cases[13];
      cases = '{
         '{32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h42C8_0000},
         '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
         '{32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h42C8_0000},
         '{32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000,
           32'h42C8_0000},
         '{32'h7FC0_0001, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h42C8_0000},
         '{32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h7F80_0001},
         '{32'hBF80_0000, 32'h7F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h42C8_0000},
         '{32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001,
           32'h7F7F_FFFF},
         '{32'h8000_0001, 32'h0000_0001, 32'h8000_0002, 32'h0000_0003, 32'h0000_0001,
           32'h0000_0002},
         '{32'h3F80_0000, 32'hBF80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h42C8_0000},
         '{32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h42C8_0000,
           32'h3F80_0000},
         '{32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h8000_0000,
           32'h42C8_0000},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF}};
      foreach (cases[i]) send_bounds(cases[i]);
   endtask

   initial begin
      int modes[8];
      int hands[8];
      int idles[8];
      int stalls[8];
      modes = '{1, 1, 0, 0, 1, 0, 1, 0};
      hands = '{0, 1, 0, 1, 0, 0, 1, 1};
      idles = '{0, 55, 0, 30, 0, 55, 0, 30};
      stalls = '{0, 0, 55, 30, 0, 0, 55, 30};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 8; p++) begin
         drain();
         write_reg(CSR_PROJ_MODE, modes[p][0]);
         write_reg(CSR_RIGHT_HANDED, hands[p][0]);
         send_idle_pct = idles[p];
         stall_pct = stalls[p];
         if (p == 4) hold_req = 1'b1;
         if (p == 0 || p == 2) send_directed();
         repeat (48) send_bounds(make_bounds());
      end
      drain();
      repeat (300) @(posedge clock);
      if (matrices.errors == 0 && matrices.rows_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
